>>> rtl/atrs_pkg.sv
// Shared types, constants and phase codes for the antenna tuner relay search.
package atrs_pkg;

  // Search phases.
  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_BASE     = 3'd1;
  localparam logic [2:0] PH_QUICK    = 3'd2;
  localparam logic [2:0] PH_FSTART   = 3'd3;
  localparam logic [2:0] PH_FPROBE   = 3'd4;
  localparam logic [2:0] PH_TIMEDOUT = 3'd5;

  // Operation codes.
  localparam logic OP_START   = 1'b0;
  localparam logic OP_MEASURE = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MATCH       = 2'd0;
  localparam logic [1:0] CFG_QUICK_MATCH = 2'd1;
  localparam logic [1:0] CFG_TRY_LIMIT   = 2'd2;
  localparam logic [1:0] CFG_MIN_FWD     = 2'd3;

  // SWR special codes.
  localparam logic [7:0] SWR_REV_HIGH = 8'd250;
  localparam logic [7:0] SWR_EQUAL    = 8'd251;
  localparam logic [7:0] SWR_OVER     = 8'd252;
  localparam logic [7:0] SWR_TIMEOUT  = 8'd253;

  // Register reset values.
  localparam logic [7:0]  RST_MATCH       = 8'd10;
  localparam logic [7:0]  RST_QUICK_MATCH = 8'd14;
  localparam logic [15:0] RST_TRY_LIMIT   = 16'd1024;
  localparam logic [9:0]  RST_MIN_FWD     = 10'd5;

  // The dividend (fwd+rev)*10 reaches 20460 and needs 15 bits.
  localparam int DIV_STEPS = 15;

  typedef struct packed {
    logic       operation;
    logic [9:0] fwd_power;
    logic [9:0] rev_power;
  } in_item_t;

  typedef struct packed {
    logic [6:0] cap_bits;
    logic [6:0] ind_bits;
    logic       cap_high_side;
    logic       done_res;
    logic [7:0] swr_value;
    logic       timed_out;
  } out_item_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic div_start;
    logic eval;
  } atrs_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic div_done;
  } atrs_sts_t;

endpackage

>>> rtl/atrs_divider.sv
// Restoring divider for the SWR quotient (fwd+rev)*10 / (fwd-rev).
module atrs_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [14:0] dividend,
  input  logic [9:0]  divisor,
  output logic        done,
  output logic [14:0] quotient
);

  logic [3:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [10:0] rem_r, rem_nxt;
  logic [14:0] quo_r, quo_nxt;
  logic [9:0]  dvs_r, dvs_nxt;
  logic [11:0] trial;

  assign quotient = quo_r;
  assign done     = busy_r && (cnt_r == 4'd0);

  // One quotient bit per cycle, most significant first.
  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    trial    = {rem_r, quo_r[14]} - {2'b00, dvs_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 4'(atrs_pkg::DIV_STEPS);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r && cnt_r != 4'd0) begin
      cnt_nxt = cnt_r - 4'd1;
      if (!trial[11]) begin
        rem_nxt = trial[10:0];
        quo_nxt = {quo_r[13:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[9:0], quo_r[14]};
        quo_nxt = {quo_r[13:0], 1'b0};
      end
    end else if (busy_r) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

endmodule

>>> rtl/atrs_datapath.sv
// Search datapath: SWR quotient, search state and next setting logic.
module atrs_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  atrs_pkg::atrs_cmd_t cmd,
  output atrs_pkg::atrs_sts_t sts,
  input  atrs_pkg::in_item_t  item,
  input  logic [7:0]          match_limit,
  input  logic [7:0]          quick_match_limit,
  input  logic [15:0]         try_limit,
  input  logic [9:0]          min_forward,
  output atrs_pkg::out_item_t result
);

  logic [2:0]  phase_r, phase_nxt;
  logic [6:0]  cur_cap_r, cur_cap_nxt, cur_ind_r, cur_ind_nxt;
  logic        cur_side_r, cur_side_nxt;
  logic [6:0]  best_cap_r, best_cap_nxt, best_ind_r, best_ind_nxt;
  logic        best_side_r, best_side_nxt;
  logic [7:0]  best_swr_r, best_swr_nxt;
  logic [15:0] try_r, try_nxt;
  logic [6:0]  step_all_r, step_all_nxt, step_cap_r, step_cap_nxt;
  logic [6:0]  step_ind_r, step_ind_nxt;
  logic [1:0]  probe_r, probe_nxt;
  logic        impr_r, impr_nxt;
  atrs_pkg::out_item_t res_r, res_nxt;

  logic [14:0] dividend, quotient;
  logic [9:0]  diff;
  logic        div_done;

  assign diff     = item.fwd_power - item.rev_power;
  assign dividend = ({5'b0, item.fwd_power} + {5'b0, item.rev_power}) * 15'd10;

  atrs_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (diff),
    .done     (div_done),
    .quotient (quotient)
  );
  assign sts.div_done = div_done;
  assign result       = res_r;

  // Emit helper mk builds the result struct.
  function automatic atrs_pkg::out_item_t mk(logic [6:0] c, logic [6:0] l, logic s,
                                             logic d, logic [7:0] w, logic t);
    atrs_pkg::out_item_t o;
    o.cap_bits = c; o.ind_bits = l; o.cap_high_side = s;
    o.done_res = d; o.swr_value = w; o.timed_out = t;
    return o;
  endfunction

  // Step evaluation: the fine seek probe loop is unrolled over at most two
  // rounds, which covers every case that can emit.
  always_comb begin
    logic [15:0] tc;
    logic        to, retry, done_fin, found;
    logic [7:0]  s;
    logic [2:0]  k;
    logic [7:0]  c8, l8;
    phase_nxt = phase_r; cur_cap_nxt = cur_cap_r; cur_ind_nxt = cur_ind_r;
    cur_side_nxt = cur_side_r; best_cap_nxt = best_cap_r; best_ind_nxt = best_ind_r;
    best_side_nxt = best_side_r; best_swr_nxt = best_swr_r; try_nxt = try_r;
    step_all_nxt = step_all_r; step_cap_nxt = step_cap_r; step_ind_nxt = step_ind_r;
    probe_nxt = probe_r; impr_nxt = impr_r; res_nxt = res_r;
    tc = '0; to = 1'b0; retry = 1'b0; done_fin = 1'b0; found = 1'b0;
    s = '0; k = '0; c8 = '0; l8 = '0;
    if (cmd.eval) begin
      if (item.operation == atrs_pkg::OP_START) begin
        try_nxt = '0; cur_cap_nxt = '0; cur_ind_nxt = '0; cur_side_nxt = 1'b0;
        best_cap_nxt = '0; best_ind_nxt = '0; best_side_nxt = 1'b0; best_swr_nxt = '0;
        step_all_nxt = '0; step_cap_nxt = '0; step_ind_nxt = '0; probe_nxt = '0;
        impr_nxt = 1'b0; phase_nxt = atrs_pkg::PH_BASE;
        res_nxt = mk(7'd0, 7'd0, 1'b0, 1'b0, 8'd0, 1'b0);
      end else if (phase_r == atrs_pkg::PH_IDLE || phase_r > atrs_pkg::PH_FPROBE) begin
        res_nxt = mk(best_cap_r, best_ind_r, best_side_r, 1'b1, best_swr_r,
                     phase_r == atrs_pkg::PH_TIMEDOUT);
      end else begin
        tc = (try_r != 16'hFFFF) ? try_r + 16'd1 : try_r;
        try_nxt = tc;
        to = tc >= try_limit;
        if (to) s = atrs_pkg::SWR_TIMEOUT;
        else if (item.fwd_power < min_forward) retry = 1'b1;
        else if (item.rev_power > item.fwd_power) s = atrs_pkg::SWR_REV_HIGH;
        else if (diff == 10'd0) s = atrs_pkg::SWR_EQUAL;
        else if (quotient >= 15'd250) s = atrs_pkg::SWR_OVER;
        else s = quotient[7:0];
        res_nxt = mk(cur_cap_r, cur_ind_r, cur_side_r, 1'b0, 8'd0, 1'b0);
        if (!retry) begin
          unique case (phase_r)
            atrs_pkg::PH_BASE: begin
              best_swr_nxt = s;
              if (to || s <= match_limit) done_fin = 1'b1;
              else begin
                phase_nxt = atrs_pkg::PH_QUICK;
                cur_cap_nxt = 7'd1; cur_ind_nxt = 7'd1; cur_side_nxt = 1'b0;
                res_nxt = mk(7'd1, 7'd1, 1'b0, 1'b0, 8'd0, 1'b0);
              end
            end
            atrs_pkg::PH_QUICK: begin
              if (s < best_swr_r) begin
                best_swr_nxt = s; best_cap_nxt = cur_cap_r;
                best_ind_nxt = cur_ind_r; best_side_nxt = cur_side_r;
              end
              if (to) done_fin = 1'b1;
              else if (cur_side_r == 1'b0) begin
                cur_side_nxt = 1'b1;
                res_nxt = mk(cur_cap_r, cur_ind_r, 1'b1, 1'b0, 8'd0, 1'b0);
              end else if (!cur_ind_r[6]) begin
                cur_side_nxt = 1'b0; cur_ind_nxt = {cur_ind_r[5:0], 1'b0};
                res_nxt = mk(cur_cap_r, {cur_ind_r[5:0], 1'b0}, 1'b0, 1'b0, 8'd0, 1'b0);
              end else if (!((best_swr_nxt <= quick_match_limit && best_cap_nxt > 7'd1)
                             || best_swr_nxt <= match_limit) && !cur_cap_r[6]) begin
                cur_side_nxt = 1'b0; cur_cap_nxt = {cur_cap_r[5:0], 1'b0};
                cur_ind_nxt = 7'd1;
                res_nxt = mk({cur_cap_r[5:0], 1'b0}, 7'd1, 1'b0, 1'b0, 8'd0, 1'b0);
              end else if (best_swr_nxt <= match_limit) begin
                done_fin = 1'b1;
              end else begin
                // Enter the fine phase at the best quick point.
                cur_cap_nxt = best_cap_nxt; cur_ind_nxt = best_ind_nxt;
                cur_side_nxt = best_side_nxt;
                step_cap_nxt = {1'b0, best_cap_nxt[6:1]};
                step_ind_nxt = {1'b0, best_ind_nxt[6:1]};
                step_all_nxt = (step_cap_nxt > step_ind_nxt) ? step_cap_nxt : step_ind_nxt;
                if (step_cap_nxt == 7'd0) step_cap_nxt = 7'd1;
                if (step_ind_nxt == 7'd0) step_ind_nxt = 7'd1;
                if (step_all_nxt == 7'd0) step_all_nxt = 7'd1;
                phase_nxt = atrs_pkg::PH_FSTART;
                res_nxt = mk(best_cap_nxt, best_ind_nxt, best_side_nxt, 1'b0, 8'd0, 1'b0);
              end
            end
            default: begin
              if (phase_r == atrs_pkg::PH_FSTART) begin
                best_swr_nxt = s; impr_nxt = 1'b0; k = 3'd0;
              end else begin
                if (s < best_swr_r) begin
                  best_swr_nxt = s; best_cap_nxt = cur_cap_r;
                  best_ind_nxt = cur_ind_r; impr_nxt = 1'b1;
                end
                k = {1'b0, probe_r} + 3'd1;
              end
              if (to) done_fin = 1'b1;
              else begin
                // Two rounds of probe search.
                for (int r = 0; r < 2; r++) begin
                  for (int j = 0; j < 4; j++) begin
                    if (!found && !done_fin && k <= 3'(j)) begin
                      c8 = {1'b0, best_cap_nxt}; l8 = {1'b0, best_ind_nxt};
                      if (j == 0) l8 = {1'b0, best_ind_nxt} + {1'b0, step_ind_nxt};
                      else if (j == 1) c8 = {1'b0, best_cap_nxt} - {1'b0, step_cap_nxt};
                      else if (j == 2) l8 = {1'b0, best_ind_nxt} - {1'b0, step_ind_nxt};
                      else c8 = {1'b0, best_cap_nxt} + {1'b0, step_cap_nxt};
                      if (!c8[7] && !l8[7]) begin
                        found = 1'b1;
                        cur_cap_nxt = c8[6:0]; cur_ind_nxt = l8[6:0];
                        cur_side_nxt = best_side_nxt; probe_nxt = 2'(j);
                        phase_nxt = atrs_pkg::PH_FPROBE;
                        res_nxt = mk(c8[6:0], l8[6:0], best_side_nxt, 1'b0, 8'd0, 1'b0);
                      end
                    end
                  end
                  if (!found && !done_fin) begin
                    if (!impr_nxt) begin
                      step_all_nxt = {1'b0, step_all_nxt[6:1]};
                      if (step_all_nxt < step_cap_nxt) step_cap_nxt = step_all_nxt;
                      if (step_all_nxt < step_ind_nxt) step_ind_nxt = step_all_nxt;
                    end
                    if (best_swr_nxt <= match_limit || step_all_nxt == 7'd0) done_fin = 1'b1;
                    else begin
                      impr_nxt = 1'b0; k = 3'd0;
                    end
                  end
                end
                if (!found) done_fin = 1'b1;
              end
            end
          endcase
          if (done_fin) begin
            phase_nxt = to ? atrs_pkg::PH_TIMEDOUT : atrs_pkg::PH_IDLE;
            cur_cap_nxt = best_cap_nxt; cur_ind_nxt = best_ind_nxt;
            cur_side_nxt = best_side_nxt;
            res_nxt = mk(best_cap_nxt, best_ind_nxt, best_side_nxt, 1'b1, best_swr_nxt, to);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= atrs_pkg::PH_IDLE;
      cur_cap_r <= '0; cur_ind_r <= '0; cur_side_r <= 1'b0;
      best_cap_r <= '0; best_ind_r <= '0; best_side_r <= 1'b0; best_swr_r <= '0;
      try_r <= '0; step_all_r <= '0; step_cap_r <= '0; step_ind_r <= '0;
      probe_r <= '0; impr_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cur_cap_r <= cur_cap_nxt; cur_ind_r <= cur_ind_nxt; cur_side_r <= cur_side_nxt;
      best_cap_r <= best_cap_nxt; best_ind_r <= best_ind_nxt;
      best_side_r <= best_side_nxt; best_swr_r <= best_swr_nxt;
      try_r <= try_nxt; step_all_r <= step_all_nxt; step_cap_r <= step_cap_nxt;
      step_ind_r <= step_ind_nxt; probe_r <= probe_nxt; impr_r <= impr_nxt;
    end
    res_r <= res_nxt;
  end

endmodule

>>> rtl/atrs_ctrl.sv
// Controller: request handshake and sequencing of divide and evaluate.
module atrs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                load,
  output atrs_pkg::atrs_cmd_t cmd,
  input  atrs_pkg::atrs_sts_t sts
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_EVAL = 2'd2;

  logic [1:0] st_r, st_nxt;
  logic       oval_r, oval_nxt;

  assign in_ready      = (st_r == S_IDLE);
  assign out_valid     = oval_r;
  assign load          = in_valid && in_ready;
  assign cmd.div_start = load;
  // Evaluate only once the result register is free or being emptied.
  assign cmd.eval      = (st_r == S_EVAL) && (!oval_r || out_ready);

  // Sequence: accept, divide, evaluate into the result register.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (load) st_nxt = S_DIV;
      S_DIV:  if (sts.div_done) st_nxt = S_EVAL;
      S_EVAL: if (cmd.eval) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  // The result stays valid until it is taken.
  always_comb begin
    oval_nxt = oval_r;
    if (cmd.eval) oval_nxt = 1'b1;
    else if (out_ready) oval_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      oval_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      oval_r <= oval_nxt;
    end
  end

endmodule

>>> rtl/antenna_tuner_relay_search_core.sv
// Top level of the antenna tuner relay search.
//   channel | direction | handshake             | payload
//   in_     | input     | in_valid / in_ready   | in_item  (operation, fwd, rev)
//   out_    | output    | out_valid / out_ready | out_item (setting, done, swr)
//   cfg_    | input     | cfg_we                | cfg_index, cfg_data
// A result becomes valid once its request has passed S_IDLE (accept), S_DIV (the
// restoring divider of the SWR quotient) and S_EVAL (the registered evaluation).
// A new request is accepted only back in S_IDLE, from the cycle the result is valid.
// Reset is synchronous and active low; configuration registers return to the reset values.
// A result not yet taken holds the evaluation of the next request, not its acceptance.
module antenna_tuner_relay_search_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  atrs_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output atrs_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  logic [7:0]  match_r, qmatch_r;
  logic [15:0] tlim_r;
  logic [9:0]  minf_r;
  atrs_pkg::in_item_t  item_r;
  atrs_pkg::atrs_cmd_t cmd;
  atrs_pkg::atrs_sts_t sts;
  logic load;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r  <= atrs_pkg::RST_MATCH;
      qmatch_r <= atrs_pkg::RST_QUICK_MATCH;
      tlim_r   <= atrs_pkg::RST_TRY_LIMIT;
      minf_r   <= atrs_pkg::RST_MIN_FWD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        atrs_pkg::CFG_MATCH:       match_r  <= cfg_data[7:0];
        atrs_pkg::CFG_QUICK_MATCH: qmatch_r <= cfg_data[7:0];
        atrs_pkg::CFG_TRY_LIMIT:   tlim_r   <= cfg_data;
        atrs_pkg::CFG_MIN_FWD:     minf_r   <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (load) item_r <= in_item;
  end

  atrs_ctrl u_ctrl (
    .clk (clk), .rst_n (rst_n),
    .in_valid (in_valid), .in_ready (in_ready),
    .out_valid (out_valid), .out_ready (out_ready),
    .load (load), .cmd (cmd), .sts (sts)
  );

  atrs_datapath u_dp (
    .clk (clk), .rst_n (rst_n), .cmd (cmd), .sts (sts),
    .item (load ? in_item : item_r),
    .match_limit (match_r), .quick_match_limit (qmatch_r),
    .try_limit (tlim_r), .min_forward (minf_r),
    .result (out_item)
  );

endmodule

>>> sim/antenna_tuner_relay_search_core_tb.sv
// Testbench for the antenna tuner relay search core: directed table plus random tunes.
`timescale 1ns / 1ps

module antenna_tuner_relay_search_core_tb;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  atrs_pkg::in_item_t  in_item;
  logic                out_valid;
  logic                out_ready;
  atrs_pkg::out_item_t out_item;
  logic                cfg_we;
  logic [1:0]          cfg_index;
  logic [15:0]         cfg_data;

  antenna_tuner_relay_search_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Predictor copy of the registers and search state.
  logic [7:0]  m_match, m_quick;
  logic [15:0] m_try_lim;
  logic [9:0]  m_min_fwd;
  logic [2:0]  s_phase;
  int unsigned s_cur_cap, s_cur_ind, s_cur_side;
  int unsigned s_best_cap, s_best_ind, s_best_side, s_best_swr;
  int unsigned s_tries, s_step_all, s_step_cap, s_step_ind, s_probe, s_improved;

  atrs_pkg::out_item_t setting_q[$];
  int        errors;
  bit        random_running;
  bit        stim_done;

  function automatic atrs_pkg::out_item_t make_setting(int unsigned c, int unsigned l,
                                                       int unsigned s, bit dn,
                                                       int unsigned swr, bit to);
    atrs_pkg::out_item_t r;
    r.cap_bits = c[6:0];
    r.ind_bits = l[6:0];
    r.cap_high_side = s[0];
    r.done_res = dn;
    r.swr_value = swr[7:0];
    r.timed_out = to;
    return r;
  endfunction

  function automatic atrs_pkg::out_item_t current_setting();
    return make_setting(s_cur_cap, s_cur_ind, s_cur_side, 1'b0, 0, 1'b0);
  endfunction

  function automatic atrs_pkg::out_item_t finish_tune(bit to);
    s_phase = to ? atrs_pkg::PH_TIMEDOUT : atrs_pkg::PH_IDLE;
    s_cur_cap = s_best_cap;
    s_cur_ind = s_best_ind;
    s_cur_side = s_best_side;
    return make_setting(s_best_cap, s_best_ind, s_best_side, 1'b1, s_best_swr, to);
  endfunction

  function automatic int unsigned swr_times_ten(int unsigned f, int unsigned r);
    int unsigned q;
    if (r > f) return atrs_pkg::SWR_REV_HIGH;
    if (f == r) return atrs_pkg::SWR_EQUAL;
    q = ((f + r) * 10) / (f - r);
    return (q >= 250) ? atrs_pkg::SWR_OVER : q;
  endfunction

  // Next fine probe around the best point, or the end of the tune.
  function automatic atrs_pkg::out_item_t next_fine_probe(int unsigned k);
    int unsigned c, l;
    bit ok;
    for (int g = 0; g < 32; g++) begin
      while (k < 4) begin
        c = s_best_cap;
        l = s_best_ind;
        case (k)
          0: begin l = s_best_ind + s_step_ind; ok = l < 128; end
          1: begin ok = s_best_cap >= s_step_cap; c = s_best_cap - s_step_cap; end
          2: begin ok = s_best_ind >= s_step_ind; l = s_best_ind - s_step_ind; end
          default: begin c = s_best_cap + s_step_cap; ok = c < 128; end
        endcase
        if (ok) begin
          s_cur_cap = c;
          s_cur_ind = l;
          s_cur_side = s_best_side;
          s_probe = k;
          s_phase = atrs_pkg::PH_FPROBE;
          return current_setting();
        end
        k++;
      end
      if (s_improved == 0) begin
        s_step_all >>= 1;
        if (s_step_all < s_step_cap) s_step_cap = s_step_all;
        if (s_step_all < s_step_ind) s_step_ind = s_step_all;
      end
      if (s_best_swr <= m_match || s_step_all == 0) return finish_tune(1'b0);
      s_improved = 0;
      k = 0;
    end
    return finish_tune(1'b0);
  endfunction

  function automatic atrs_pkg::out_item_t end_quick_sweep();
    if (s_best_swr <= m_match) return finish_tune(1'b0);
    s_cur_cap = s_best_cap;
    s_cur_ind = s_best_ind;
    s_cur_side = s_best_side;
    s_step_cap = s_best_cap >> 1;
    s_step_ind = s_best_ind >> 1;
    s_step_all = (s_step_cap > s_step_ind) ? s_step_cap : s_step_ind;
    if (s_step_cap == 0) s_step_cap = 1;
    if (s_step_ind == 0) s_step_ind = 1;
    if (s_step_all == 0) s_step_all = 1;
    s_phase = atrs_pkg::PH_FSTART;
    return current_setting();
  endfunction

  function automatic atrs_pkg::out_item_t advance_quick_sweep();
    if (s_cur_side == 0) begin
      s_cur_side = 1;
      return current_setting();
    end
    s_cur_side = 0;
    s_cur_ind <<= 1;
    if (s_cur_ind < 128) return current_setting();
    if ((s_best_swr <= m_quick && s_best_cap > 1) || s_best_swr <= m_match)
      return end_quick_sweep();
    s_cur_cap <<= 1;
    if (s_cur_cap >= 128) return end_quick_sweep();
    s_cur_ind = 1;
    return current_setting();
  endfunction

  // Predicts the setting returned for one request.
  function automatic atrs_pkg::out_item_t predict_setting(atrs_pkg::in_item_t it);
    int unsigned s;
    bit to;
    if (it.operation == atrs_pkg::OP_START) begin
      s_tries = 0;
      s_cur_cap = 0; s_cur_ind = 0; s_cur_side = 0;
      s_best_cap = 0; s_best_ind = 0; s_best_side = 0; s_best_swr = 0;
      s_step_all = 0; s_step_cap = 0; s_step_ind = 0; s_probe = 0; s_improved = 0;
      s_phase = atrs_pkg::PH_BASE;
      return current_setting();
    end
    if (s_phase < atrs_pkg::PH_BASE || s_phase > atrs_pkg::PH_FPROBE)
      return make_setting(s_best_cap, s_best_ind, s_best_side, 1'b1, s_best_swr,
                          s_phase == atrs_pkg::PH_TIMEDOUT);
    if (s_tries < 16'hFFFF) s_tries++;
    to = s_tries >= m_try_lim;
    if (to) s = atrs_pkg::SWR_TIMEOUT;
    else if (it.fwd_power < m_min_fwd) return current_setting();
    else s = swr_times_ten(it.fwd_power, it.rev_power);
    case (s_phase)
      atrs_pkg::PH_BASE: begin
        s_best_swr = s;
        if (to) return finish_tune(1'b1);
        if (s <= m_match) return finish_tune(1'b0);
        s_phase = atrs_pkg::PH_QUICK;
        s_cur_cap = 1; s_cur_ind = 1; s_cur_side = 0;
        return current_setting();
      end
      atrs_pkg::PH_QUICK: begin
        if (s < s_best_swr) begin
          s_best_swr = s; s_best_cap = s_cur_cap;
          s_best_ind = s_cur_ind; s_best_side = s_cur_side;
        end
        if (to) return finish_tune(1'b1);
        return advance_quick_sweep();
      end
      atrs_pkg::PH_FSTART: begin
        s_best_swr = s;
        if (to) return finish_tune(1'b1);
        s_improved = 0;
        return next_fine_probe(0);
      end
      default: begin
        if (s < s_best_swr) begin
          s_best_swr = s; s_best_cap = s_cur_cap; s_best_ind = s_cur_ind; s_improved = 1;
        end
        if (to) return finish_tune(1'b1);
        return next_fine_probe((s_probe & 3) + 1);
      end
    endcase
  endfunction

  // Random gap length: mostly short, now and then long.
  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      atrs_pkg::CFG_MATCH:       m_match = val[7:0];
      atrs_pkg::CFG_QUICK_MATCH: m_quick = val[7:0];
      atrs_pkg::CFG_TRY_LIMIT:   m_try_lim = val;
      default:                   m_min_fwd = val[9:0];
    endcase
    @(posedge clk);
  endtask

  // Sends one request; the expected setting is queued when it is accepted.
  task automatic send_request(logic op, logic [9:0] f, logic [9:0] r, bit check_typed,
                              atrs_pkg::out_item_t typed);
    atrs_pkg::in_item_t  it;
    atrs_pkg::out_item_t exp_set;
    int gap;
    it.operation = op;
    it.fwd_power = f;
    it.rev_power = r;
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    exp_set = predict_setting(it);
    if (check_typed && exp_set != typed)
      $error("typed row disagrees with predictor: %h vs %h", typed, exp_set);
    setting_q.push_back(check_typed ? typed : exp_set);
    // Valid stays high into the next request when there is no gap.
    gap = gap_cycles();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (setting_q.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  // Measurement that lands near a chosen SWR, with occasional noise.
  task automatic random_measure();
    logic [9:0] f, r;
    int pick;
    pick = $urandom_range(0, 99);
    f = 10'($urandom_range(0, 1023));
    if (pick < 60) begin
      f = 10'($urandom_range(50, 1023));
      r = 10'($urandom_range(0, f / 3));
    end else if (pick < 75) begin
      f = 10'($urandom_range(200, 1023));
      r = 10'($urandom_range(0, f / 40));
    end else begin
      r = 10'($urandom_range(0, 1023));
    end
    send_request(atrs_pkg::OP_MEASURE, f, r, 1'b0, '0);
  endtask

  typedef struct {
    logic                op;
    logic [9:0]          f;
    logic [9:0]          r;
    bit                  typed;
    atrs_pkg::out_item_t exp_set;
  } dir_row_t;

  dir_row_t dir_rows[$];

  // Stimulus process.
  initial begin
    int n_sent;
    int tune_len;
    cfg_we = 1'b0;
    cfg_index = atrs_pkg::CFG_MATCH;
    cfg_data = '0;
    in_valid = 1'b0;
    in_item = '0;
    rst_n = 1'b0;
    stim_done = 1'b0;
    random_running = 1'b0;
    errors = 0;
    m_match = atrs_pkg::RST_MATCH; m_quick = atrs_pkg::RST_QUICK_MATCH;
    m_try_lim = atrs_pkg::RST_TRY_LIMIT; m_min_fwd = atrs_pkg::RST_MIN_FWD;
    s_phase = atrs_pkg::PH_IDLE;
    s_cur_cap = 0; s_cur_ind = 0; s_cur_side = 0;
    s_best_cap = 0; s_best_ind = 0; s_best_side = 0; s_best_swr = 0;
    s_tries = 0; s_step_all = 0; s_step_cap = 0; s_step_ind = 0;
    s_probe = 0; s_improved = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows: idle measurement, special codes, retry, extremes.
    dir_rows = '{
      '{atrs_pkg::OP_MEASURE, 10'd0,    10'd0,    1'b1,
        make_setting(0, 0, 0, 1'b1, 0, 1'b0)},
      '{atrs_pkg::OP_START,   10'd1023, 10'd1023, 1'b1,
        make_setting(0, 0, 0, 1'b0, 0, 1'b0)},
      '{atrs_pkg::OP_MEASURE, 10'd4,    10'd0,    1'b1,
        make_setting(0, 0, 0, 1'b0, 0, 1'b0)},
      '{atrs_pkg::OP_MEASURE, 10'd100,  10'd50,   1'b1,
        make_setting(1, 1, 0, 1'b0, 0, 1'b0)},
      '{atrs_pkg::OP_MEASURE, 10'd100,  10'd200,  1'b1,
        make_setting(1, 1, 1, 1'b0, 0, 1'b0)},
      '{atrs_pkg::OP_MEASURE, 10'd512,  10'd512,  1'b1,
        make_setting(1, 2, 0, 1'b0, 0, 1'b0)},
      '{atrs_pkg::OP_MEASURE, 10'd1023, 10'd1000, 1'b1,
        make_setting(1, 2, 1, 1'b0, 0, 1'b0)},
      '{atrs_pkg::OP_MEASURE, 10'd1023, 10'd0,    1'b0, '0},
      '{atrs_pkg::OP_MEASURE, 10'd1000, 10'd10,   1'b0, '0},
      '{atrs_pkg::OP_START,   10'd0,    10'd0,    1'b1,
        make_setting(0, 0, 0, 1'b0, 0, 1'b0)},
      '{atrs_pkg::OP_MEASURE, 10'd1023, 10'd0,    1'b1,
        make_setting(0, 0, 0, 1'b1, 10, 1'b0)},
      '{atrs_pkg::OP_MEASURE, 10'd300,  10'd300,  1'b1,
        make_setting(0, 0, 0, 1'b1, 10, 1'b0)}
    };
    foreach (dir_rows[i])
      send_request(dir_rows[i].op, dir_rows[i].f, dir_rows[i].r, dir_rows[i].typed,
                   dir_rows[i].exp_set);
    drain_results();

    // Try limit of one: the first reading times out.
    write_reg(atrs_pkg::CFG_TRY_LIMIT, 16'd1);
    send_request(atrs_pkg::OP_START, 10'd0, 10'd0, 1'b0, '0);
    send_request(atrs_pkg::OP_MEASURE, 10'd800, 10'd10, 1'b1,
                 make_setting(0, 0, 0, 1'b1, 253, 1'b1));
    send_request(atrs_pkg::OP_MEASURE, 10'd800, 10'd10, 1'b1,
                 make_setting(0, 0, 0, 1'b1, 253, 1'b1));
    drain_results();

    // Random phases, each with its own register setting.
    n_sent = 0;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin write_reg(atrs_pkg::CFG_MATCH, 16'd0);
                 write_reg(atrs_pkg::CFG_QUICK_MATCH, 16'd0);
                 write_reg(atrs_pkg::CFG_TRY_LIMIT, 16'hFFFF);
                 write_reg(atrs_pkg::CFG_MIN_FWD, 16'd0); end
        1: begin write_reg(atrs_pkg::CFG_MATCH, 16'd255);
                 write_reg(atrs_pkg::CFG_QUICK_MATCH, 16'd255);
                 write_reg(atrs_pkg::CFG_MIN_FWD, 16'd1023); end
        2: begin write_reg(atrs_pkg::CFG_MATCH, 16'(atrs_pkg::RST_MATCH));
                 write_reg(atrs_pkg::CFG_QUICK_MATCH, 16'(atrs_pkg::RST_QUICK_MATCH));
                 write_reg(atrs_pkg::CFG_TRY_LIMIT, 16'd40);
                 write_reg(atrs_pkg::CFG_MIN_FWD, 16'(atrs_pkg::RST_MIN_FWD)); end
        3: write_reg(atrs_pkg::CFG_TRY_LIMIT, atrs_pkg::RST_TRY_LIMIT);
        4: begin write_reg(atrs_pkg::CFG_MATCH, 16'd13);
                 write_reg(atrs_pkg::CFG_QUICK_MATCH, 16'd30); end
        5: begin write_reg(atrs_pkg::CFG_MATCH, 16'd3);
                 write_reg(atrs_pkg::CFG_MIN_FWD, 16'd60); end
        6: begin write_reg(atrs_pkg::CFG_TRY_LIMIT, 16'd7);
                 write_reg(atrs_pkg::CFG_MIN_FWD, 16'd1); end
        default: begin write_reg(atrs_pkg::CFG_TRY_LIMIT, 16'd300);
                       write_reg(atrs_pkg::CFG_MATCH, 16'd11); end
      endcase
      random_running = 1'b1;
      // Phase one's minimum forward forces mostly retries; keep it short.
      for (int k = 0; k < ((ph == 1) ? 40 : 150); ) begin
        send_request(atrs_pkg::OP_START, 10'($urandom_range(0, 1023)),
                     10'($urandom_range(0, 1023)), 1'b0, '0);
        tune_len = $urandom_range(5, 80);
        for (int j = 0; j < tune_len; j++) random_measure();
        k += tune_len + 1;
        n_sent += tune_len + 1;
      end
      drain_results();
    end
    stim_done = 1'b1;
  end

  // Receiver with random stalls and one long hold-off while requests keep coming.
  initial begin
    int gap;
    out_ready = 1'b0;
    @(posedge rst_n);
    repeat (300) begin
      out_ready <= ($urandom_range(0, 3) != 0);
      @(posedge clk);
    end
    @(posedge clk iff random_running);
    out_ready <= 1'b0;
    repeat (200) @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      gap = gap_cycles();
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // Compare each returned setting with the oldest prediction.
  always @(posedge clk) begin
    atrs_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (setting_q.size() == 0) begin
        $error("unexpected result %h", out_item);
        errors++;
      end else begin
        want = setting_q.pop_front();
        if (out_item.cap_bits != want.cap_bits) begin
          $error("cap_bits expected %0d got %0d", want.cap_bits, out_item.cap_bits); errors++;
        end
        if (out_item.ind_bits != want.ind_bits) begin
          $error("ind_bits expected %0d got %0d", want.ind_bits, out_item.ind_bits); errors++;
        end
        if (out_item.cap_high_side != want.cap_high_side) begin
          $error("cap_high_side expected %0d got %0d", want.cap_high_side,
                 out_item.cap_high_side); errors++;
        end
        if (out_item.done_res != want.done_res) begin
          $error("done_res expected %0d got %0d", want.done_res, out_item.done_res); errors++;
        end
        if (out_item.swr_value != want.swr_value) begin
          $error("swr_value expected %0d got %0d", want.swr_value, out_item.swr_value); errors++;
        end
        if (out_item.timed_out != want.timed_out) begin
          $error("timed_out expected %0d got %0d", want.timed_out, out_item.timed_out); errors++;
        end
      end
    end
  end

  // End of run.
  initial begin
    @(posedge stim_done);
    repeat (30) @(posedge clk);
    if (errors == 0 && setting_q.size() == 0) begin
      $display("** antenna_tuner_relay_search_core: PASSED **");
    end else begin
      $display("** antenna_tuner_relay_search_core: FAILED **");
    end
    $finish;
  end

  // Timeout guard.
  initial begin
    #20ms;
    $display("** antenna_tuner_relay_search_core: FAILED **");
    $finish;
  end

endmodule

>>> sim.f
rtl/atrs_pkg.sv
rtl/atrs_divider.sv
rtl/atrs_datapath.sv
rtl/atrs_ctrl.sv
rtl/antenna_tuner_relay_search_core.sv
sim/antenna_tuner_relay_search_core_tb.sv
